>>> rtl/vvpu_pkg.sv
// ----------------------------------------------------------------------------
// vvpu_pkg
// shared constants, codes and helpers of the velocity verlet particle update
// ----------------------------------------------------------------------------
`default_nettype none

package vvpu_pkg;

   localparam int PARTICLES = 1024;
   localparam int FRAC_BITS = 16;
   localparam int PART_W    = $clog2(PARTICLES);

   // number of stages of the pipelined units
   localparam int DIV_N  = 64;
   localparam int SQRT_N = 32;

   // stage numbers of the main pipeline
   localparam int S_MUL  = 1;
   localparam int S_KQ   = S_MUL + DIV_N;
   localparam int S_RD   = S_KQ + 1;
   localparam int S_V1   = S_RD + 1;
   localparam int S_SQR  = S_V1 + 1;
   localparam int S_SUM  = S_SQR + 1;
   localparam int S_CMP  = S_SUM + 1;
   localparam int S_MAG  = S_CMP + SQRT_N;
   localparam int S_LMUL = S_MAG + 1;
   localparam int S_LQ   = S_LMUL + DIV_N;
   localparam int S_VL   = S_LQ + 1;
   localparam int S_EST  = S_VL + 1;
   localparam int S_TMUL = S_EST + 1;
   localparam int S_LAST = S_TMUL + 1;

   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_FIRST  = 2'd1,
      KIND_SECOND = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CSR_TIME_STEP = 2'd0,
      CSR_HALF_KICK = 2'd1,
      CSR_VEL_LIMIT = 2'd2,
      CSR_SMOOTHED  = 2'd3
   } csr_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (x < -64'sh0000_0000_8000_0000) r = -32'sh8000_0000;
      else r = x[31:0];
      return r;
   endfunction

   function automatic logic [31:0] abs32(input logic [31:0] x);
      logic [31:0] r;
      r = x[31] ? 32'(-x) : x;
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/vvpu_div.sv
// ----------------------------------------------------------------------------
// vvpu_div
// pipelined restoring divider, 64-bit dividend by 32-bit divisor, one bit a stage
// ----------------------------------------------------------------------------
`default_nettype none

module vvpu_div (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [63:0] num,
   input  wire logic [31:0] den,
   output logic      [63:0] quo
);

   typedef struct packed {
      logic [31:0] rem;
      logic [63:0] nq;   // dividend bits shift out on top, quotient bits in below
      logic [31:0] den;
   } div_stage_type;

   function automatic div_stage_type div_step(input div_stage_type s);
      logic [32:0]   r;
      logic          ge;
      div_stage_type o;
      r     = {s.rem, s.nq[63]};
      ge    = r >= {1'b0, s.den};
      o.rem = ge ? 32'(r - {1'b0, s.den}) : r[31:0];
      o.nq  = {s.nq[62:0], ge};
      o.den = s.den;
      return o;
   endfunction

   div_stage_type st_ff [vvpu_pkg::DIV_N];
   div_stage_type init;

   assign init = '{rem: 32'd0, nq: num, den: den};

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= div_step(init);
         for (int i = 1; i < vvpu_pkg::DIV_N; i++) st_ff[i] <= div_step(st_ff[i-1]);
      end
   end

   assign quo = st_ff[vvpu_pkg::DIV_N-1].nq;

endmodule

`default_nettype wire

>>> rtl/vvpu_sqrt.sv
// ----------------------------------------------------------------------------
// vvpu_sqrt
// pipelined integer square root of a 64-bit value, one root bit a stage
// ----------------------------------------------------------------------------
`default_nettype none

module vvpu_sqrt (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [63:0] radicand,
   output logic      [31:0] root
);

   typedef struct packed {
      logic [33:0] rem;
      logic [31:0] root;
      logic [63:0] x;
   } sqrt_stage_type;

   function automatic sqrt_stage_type sqrt_step(input sqrt_stage_type s);
      logic [35:0]    r;
      logic [35:0]    t;
      logic           ge;
      sqrt_stage_type o;
      r      = {s.rem, s.x[63:62]};
      t      = {2'b00, s.root, 2'b01};
      ge     = r >= t;
      o.rem  = ge ? 34'(r - t) : r[33:0];
      o.root = {s.root[30:0], ge};
      o.x    = {s.x[61:0], 2'b00};
      return o;
   endfunction

   sqrt_stage_type st_ff [vvpu_pkg::SQRT_N];
   sqrt_stage_type init;

   assign init = '{rem: 34'd0, root: 32'd0, x: radicand};

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= sqrt_step(init);
         for (int i = 1; i < vvpu_pkg::SQRT_N; i++) st_ff[i] <= sqrt_step(st_ff[i-1]);
      end
   end

   assign root = st_ff[vvpu_pkg::SQRT_N-1].root;

endmodule

`default_nettype wire

>>> rtl/velocity_verlet_particle_update_top.sv
// ----------------------------------------------------------------------------
// velocity_verlet_particle_update_top
// per-particle velocity verlet kick/drift with speed limit, q16.16 saturating
// ----------------------------------------------------------------------------
// Position, velocity and energy of every particle sit in one on-chip memory,
// one wide word per particle. One item enters per cycle while req_stall is
// low; the path runs through two 64-stage pipelined dividers (kick and speed
// rescale) and a 32-stage pipelined square root in series, with the memory
// read ahead of the limit path and the write back at the end. An item whose
// particle is still in flight is held off (req_stall) until the earlier item
// has written back; distinct particles stream at one a cycle while the
// output is not stalled. Kind 3 and out-of-range particles are taken and
// dropped with no result. The memory is undefined after reset and needs no
// clearing pass; stepping a particle that was never loaded gives undefined
// fields. The pipeline freezes only when the output register holds an item
// that is stalled. The user must write configuration through
// csr_write/csr_index/csr_data only while the block is idle; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module velocity_verlet_particle_update_top (
   input  wire logic               clock,
   input  wire logic               reset,
   // item input
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic        [1:0]  req_kind,
   input  wire logic        [9:0]  req_particle,
   input  wire logic signed [31:0] req_vec_a_x,
   input  wire logic signed [31:0] req_vec_a_y,
   input  wire logic signed [31:0] req_vec_a_z,
   input  wire logic signed [31:0] req_vec_b_x,
   input  wire logic signed [31:0] req_vec_b_y,
   input  wire logic signed [31:0] req_vec_b_z,
   input  wire logic        [31:0] req_mass,
   input  wire logic signed [31:0] req_scalar_in,
   // result output
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic             [9:0]  rsp_particle_out,
   output logic signed      [31:0] rsp_vel_x_out,
   output logic signed      [31:0] rsp_vel_y_out,
   output logic signed      [31:0] rsp_vel_z_out,
   output logic signed      [31:0] rsp_pos_x_out,
   output logic signed      [31:0] rsp_pos_y_out,
   output logic signed      [31:0] rsp_pos_z_out,
   output logic signed      [31:0] rsp_est_vel_x,
   output logic signed      [31:0] rsp_est_vel_y,
   output logic signed      [31:0] rsp_est_vel_z,
   output logic signed      [31:0] rsp_energy_out,
   // configuration
   input  wire logic               csr_write,
   input  wire logic        [1:0]  csr_index,
   input  wire logic        [31:0] csr_data
);

   localparam int LAST = vvpu_pkg::S_LAST;
   localparam int F    = vvpu_pkg::FRAC_BITS;

   // item fields that travel along the whole pipeline
   typedef struct packed {
      vvpu_pkg::kind_type kind;
      logic [9:0]         idx;
      logic [2:0][31:0]   a;
      logic [2:0][31:0]   b;
      logic [31:0]        sc;
      logic               mzero;
   } side_type;

   // working values, from the memory read on
   typedef struct packed {
      logic [2:0][33:0] dv;
      logic [2:0][31:0] v1;
      logic [2:0][31:0] p;
      logic [31:0]      e;
      logic [2:0][62:0] sqr;
      logic [61:0]      limsq;
      logic [63:0]      sq;
      logic             need;
      logic [2:0][31:0] vl;
      logic [2:0][31:0] est;
      logic [2:0][31:0] w;
      logic [2:0][64:0] tp;
      logic [64:0]      te;
   } work_type;

   // one memory word per particle
   typedef struct packed {
      logic [31:0]      e;
      logic [2:0][31:0] v;
      logic [2:0][31:0] p;
   } state_type;

   // configuration registers
   logic [31:0] time_step_ff;
   logic [31:0] half_kick_ff;
   logic [30:0] vel_limit_ff;
   logic        smoothed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= '0;
         half_kick_ff <= '0;
         vel_limit_ff <= '0;
         smoothed_ff  <= 1'b0;
      end else if (csr_write) begin
         unique case (vvpu_pkg::csr_type'(csr_index))
            vvpu_pkg::CSR_TIME_STEP: time_step_ff <= csr_data;
            vvpu_pkg::CSR_HALF_KICK: half_kick_ff <= csr_data;
            vvpu_pkg::CSR_VEL_LIMIT: vel_limit_ff <= csr_data[30:0];
            vvpu_pkg::CSR_SMOOTHED:  smoothed_ff  <= csr_data[0];
         endcase
      end
   end

   // pipeline registers
   logic [LAST:0] vld_ff;
   side_type      sb_ff [LAST+1];
   work_type      wk_ff [vvpu_pkg::S_RD:LAST];
   logic [2:0][63:0] kprod_ff;
   logic [31:0]      kmass_ff;
   logic [2:0][63:0] lprod_ff;
   logic [31:0]      lmag_ff;
   state_type        rd_ff;
   // the registered mass feeds only the kick divider
   logic [31:0]      req_mass_ff;

   // particle state memory
   state_type state_mem [vvpu_pkg::PARTICLES];

   logic [2:0][63:0] kquo;
   logic [2:0][63:0] lquo;
   logic [31:0]      mag;

   // handshake and hazard check
   logic     advance;
   logic     hit;
   logic     keep;
   logic     take;
   side_type sb_in;

   assign advance = !(vld_ff[LAST] && rsp_stall);

   always_comb begin
      hit = 1'b0;
      // items not yet written back, the output stage has written already
      for (int i = 0; i < LAST; i++) begin
         if (vld_ff[i] && sb_ff[i].idx == req_particle) hit = 1'b1;
      end
   end

   assign keep = (req_kind == vvpu_pkg::KIND_LOAD || req_kind == vvpu_pkg::KIND_FIRST ||
                  req_kind == vvpu_pkg::KIND_SECOND) &&
                 (32'(req_particle) < vvpu_pkg::PARTICLES);
   assign req_stall = !advance || hit;
   assign take      = req_valid && !req_stall && keep;

   assign sb_in = '{kind:  vvpu_pkg::kind_type'(req_kind),
                    idx:   req_particle,
                    a:     {req_vec_a_z, req_vec_a_y, req_vec_a_x},
                    b:     {req_vec_b_z, req_vec_b_y, req_vec_b_x},
                    sc:    req_scalar_in,
                    mzero: req_mass == 32'd0};

   // per-stage arithmetic
   work_type rd_in, v1_in, sqr_in, sum_in, cmp_in, vl_in, est_in, tmul_in, last_in;

   always_comb begin
      logic [32:0]        qc;
      logic [33:0]        qs;
      logic signed [63:0] pn;
      logic signed [63:0] en;

      // kick: clamp quotient, restore sign of the force
      rd_in = '0;
      for (int k = 0; k < 3; k++) begin
         qc = (kquo[k] > 64'h1_0000_0000) ? 33'h1_0000_0000 : kquo[k][32:0];
         qs = sb_ff[vvpu_pkg::S_KQ].a[k][31] ? 34'(-{1'b0, qc}) : {1'b0, qc};
         rd_in.dv[k] = sb_ff[vvpu_pkg::S_KQ].mzero ? 34'd0 : qs;
      end

      // kicked velocity, stored position and energy
      v1_in = wk_ff[vvpu_pkg::S_RD];
      for (int k = 0; k < 3; k++) begin
         v1_in.v1[k] = vvpu_pkg::sat32(64'($signed(rd_ff.v[k])) +
                                       64'($signed(wk_ff[vvpu_pkg::S_RD].dv[k])));
         v1_in.p[k]  = rd_ff.p[k];
      end
      v1_in.e = rd_ff.e;

      // squared speed against the squared limit
      sqr_in = wk_ff[vvpu_pkg::S_V1];
      for (int k = 0; k < 3; k++) begin
         sqr_in.sqr[k] = 63'(64'(vvpu_pkg::abs32(wk_ff[vvpu_pkg::S_V1].v1[k])) *
                             64'(vvpu_pkg::abs32(wk_ff[vvpu_pkg::S_V1].v1[k])));
      end
      sqr_in.limsq = 62'(vel_limit_ff) * 62'(vel_limit_ff);

      sum_in    = wk_ff[vvpu_pkg::S_SQR];
      sum_in.sq = 64'(wk_ff[vvpu_pkg::S_SQR].sqr[0]) + 64'(wk_ff[vvpu_pkg::S_SQR].sqr[1]) +
                  64'(wk_ff[vvpu_pkg::S_SQR].sqr[2]);

      cmp_in      = wk_ff[vvpu_pkg::S_SUM];
      cmp_in.need = (vel_limit_ff != 31'd0) &&
                    (wk_ff[vvpu_pkg::S_SUM].sq > {2'b00, wk_ff[vvpu_pkg::S_SUM].limsq});

      // rescaled velocity
      vl_in = wk_ff[vvpu_pkg::S_LQ];
      for (int k = 0; k < 3; k++) begin
         qs = wk_ff[vvpu_pkg::S_LQ].v1[k][31] ? 34'(-{1'b0, lquo[k][32:0]}) :
                                                {1'b0, lquo[k][32:0]};
         vl_in.vl[k] = wk_ff[vvpu_pkg::S_LQ].need ? vvpu_pkg::sat32(64'($signed(qs))) :
                                                    wk_ff[vvpu_pkg::S_LQ].v1[k];
      end

      // extrapolated velocity and drift velocity
      est_in = wk_ff[vvpu_pkg::S_VL];
      for (int k = 0; k < 3; k++) begin
         est_in.est[k] = vvpu_pkg::sat32(64'($signed(wk_ff[vvpu_pkg::S_VL].vl[k])) +
                                         64'($signed(wk_ff[vvpu_pkg::S_VL].dv[k])));
         est_in.w[k]   = smoothed_ff ?
            vvpu_pkg::sat32(64'($signed(wk_ff[vvpu_pkg::S_VL].vl[k])) +
                            64'($signed(sb_ff[vvpu_pkg::S_VL].b[k]) >>> 1)) :
            wk_ff[vvpu_pkg::S_VL].vl[k];
      end

      // time step products
      tmul_in = wk_ff[vvpu_pkg::S_EST];
      for (int k = 0; k < 3; k++) begin
         tmul_in.tp[k] = $signed({1'b0, time_step_ff}) * $signed(wk_ff[vvpu_pkg::S_EST].w[k]);
      end
      tmul_in.te = $signed({1'b0, time_step_ff}) * $signed(sb_ff[vvpu_pkg::S_EST].sc);

      // final values per kind
      last_in = wk_ff[vvpu_pkg::S_TMUL];
      case (sb_ff[vvpu_pkg::S_TMUL].kind)
         vvpu_pkg::KIND_LOAD: begin
            last_in.p  = sb_ff[vvpu_pkg::S_TMUL].a;
            last_in.vl = sb_ff[vvpu_pkg::S_TMUL].b;
            last_in.est = sb_ff[vvpu_pkg::S_TMUL].b;
            last_in.e  = sb_ff[vvpu_pkg::S_TMUL].sc;
         end
         vvpu_pkg::KIND_FIRST: begin
            for (int k = 0; k < 3; k++) begin
               pn = 64'($signed(wk_ff[vvpu_pkg::S_TMUL].tp[k]) >>> F);
               last_in.p[k] = vvpu_pkg::sat32(64'($signed(wk_ff[vvpu_pkg::S_TMUL].p[k])) + pn);
            end
         end
         default: begin
            en = 64'($signed(wk_ff[vvpu_pkg::S_TMUL].te) >>> F);
            last_in.e   = vvpu_pkg::sat32(64'($signed(wk_ff[vvpu_pkg::S_TMUL].e)) + en);
            last_in.est = wk_ff[vvpu_pkg::S_TMUL].vl;
         end
      endcase
   end

   // valid line
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LAST-1:0], take};
      end
   end

   // payload lines, special stages take their own value instead of the plain copy
   always_ff @(posedge clock) begin
      if (advance) begin
         sb_ff[0] <= sb_in;
         for (int i = 1; i <= LAST; i++) sb_ff[i] <= sb_ff[i-1];
         for (int i = vvpu_pkg::S_RD + 1; i <= LAST; i++) begin
            if (i != vvpu_pkg::S_V1 && i != vvpu_pkg::S_SQR && i != vvpu_pkg::S_SUM &&
                i != vvpu_pkg::S_CMP && i != vvpu_pkg::S_VL && i != vvpu_pkg::S_EST &&
                i != vvpu_pkg::S_TMUL && i != LAST) begin
               wk_ff[i] <= wk_ff[i-1];
            end
         end
         wk_ff[vvpu_pkg::S_RD]   <= rd_in;
         wk_ff[vvpu_pkg::S_V1]   <= v1_in;
         wk_ff[vvpu_pkg::S_SQR]  <= sqr_in;
         wk_ff[vvpu_pkg::S_SUM]  <= sum_in;
         wk_ff[vvpu_pkg::S_CMP]  <= cmp_in;
         wk_ff[vvpu_pkg::S_VL]   <= vl_in;
         wk_ff[vvpu_pkg::S_EST]  <= est_in;
         wk_ff[vvpu_pkg::S_TMUL] <= tmul_in;
         wk_ff[LAST]             <= last_in;

         // kick numerators
         for (int k = 0; k < 3; k++) begin
            kprod_ff[k] <= 64'(vvpu_pkg::abs32(sb_ff[0].a[k])) * 64'(half_kick_ff);
         end
         kmass_ff <= req_mass_ff;

         // rescale numerators and the speed
         for (int k = 0; k < 3; k++) begin
            lprod_ff[k] <= 64'(vvpu_pkg::abs32(wk_ff[vvpu_pkg::S_MAG].v1[k])) *
                           64'(vel_limit_ff);
         end
         lmag_ff <= mag;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) req_mass_ff <= req_mass;
   end

   // memory read ahead of the kicked-velocity stage
   logic [vvpu_pkg::PART_W-1:0] raddr;
   logic [vvpu_pkg::PART_W-1:0] waddr;

   assign raddr = vvpu_pkg::PART_W'(sb_ff[vvpu_pkg::S_KQ].idx);
   assign waddr = vvpu_pkg::PART_W'(sb_ff[vvpu_pkg::S_TMUL].idx);

   always_ff @(posedge clock) begin
      if (advance) begin
         rd_ff <= state_mem[raddr];
      end
   end

   // write back as the item enters the output register
   always_ff @(posedge clock) begin
      if (advance && vld_ff[vvpu_pkg::S_TMUL]) begin
         state_mem[waddr] <= '{e: last_in.e, v: last_in.vl, p: last_in.p};
      end
   end

   // pipelined units
   for (genvar k = 0; k < 3; k++) begin : g_lane
      vvpu_div u_kick_div (
         .clock (clock),
         .en    (advance),
         .num   (kprod_ff[k]),
         .den   (kmass_ff),
         .quo   (kquo[k])
      );

      vvpu_div u_limit_div (
         .clock (clock),
         .en    (advance),
         .num   (lprod_ff[k]),
         .den   (lmag_ff),
         .quo   (lquo[k])
      );
   end

   vvpu_sqrt u_sqrt (
      .clock    (clock),
      .en       (advance),
      .radicand (wk_ff[vvpu_pkg::S_CMP].sq),
      .root     (mag)
   );

   // result item
   assign rsp_valid        = vld_ff[LAST];
   assign rsp_particle_out = sb_ff[LAST].idx;
   assign rsp_vel_x_out    = wk_ff[LAST].vl[0];
   assign rsp_vel_y_out    = wk_ff[LAST].vl[1];
   assign rsp_vel_z_out    = wk_ff[LAST].vl[2];
   assign rsp_pos_x_out    = wk_ff[LAST].p[0];
   assign rsp_pos_y_out    = wk_ff[LAST].p[1];
   assign rsp_pos_z_out    = wk_ff[LAST].p[2];
   assign rsp_est_vel_x    = wk_ff[LAST].est[0];
   assign rsp_est_vel_y    = wk_ff[LAST].est[1];
   assign rsp_est_vel_z    = wk_ff[LAST].est[2];
   assign rsp_energy_out   = wk_ff[LAST].e;

endmodule

`default_nettype wire
